// File: rtl/qs_pkg.sv
// qs_pkg: shared types and constants of the quicksort engine
// no dependencies; used by the interfaces, qs_ctrl, qs_dp and quicksort_engine
`timescale 1ns / 1ps

package qs_pkg;

  localparam int unsigned QS_MAX_ITEMS   = 64;
  localparam int unsigned QS_VALUE_WIDTH = 32;

  // element store read address select
  typedef enum logic [1:0] {
    RD_L  = 2'd0,
    RD_R  = 2'd1,
    RD_LO = 2'd2,
    RD_K  = 2'd3
  } rd_sel_t;

  // element store write select
  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_IN    = 3'd1,
    WR_L_B   = 3'd2,
    WR_R_A   = 3'd3,
    WR_LO_B  = 3'd4,
    WR_R_PIV = 3'd5
  } wr_sel_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    push_init;
    logic    push_right;
    logic    push_left;
    logic    pop;
    logic    load_range;
    logic    pivot_ld;
    logic    l_inc;
    logic    r_dec;
    logic    a_ld;
    logic    b_ld;
    logic    k_clr;
    logic    k_inc;
    logic    run_clr;
  } qs_cmd_t;

  typedef struct packed {
    logic sp_zero;
    logic l_go;
    logic r_go;
    logic l_lt_r;
    logic k_last;
  } qs_sts_t;

endpackage

// File: rtl/qs_in_if.sv
// qs_in_if, qs_out_if: valid/ready channels of the quicksort engine
// depends on qs_pkg for the default value width
`timescale 1ns / 1ps

interface qs_in_if #(
  parameter int unsigned VALUE_WIDTH = qs_pkg::QS_VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          is_final;

  modport source (output valid, output value, output is_final, input ready);
  modport sink   (input valid, input value, input is_final, output ready);
endinterface

interface qs_out_if #(
  parameter int unsigned VALUE_WIDTH = qs_pkg::QS_VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sorted_value;
  logic                          is_final_res;
  logic                          overflowed;

  modport source (output valid, output sorted_value, output is_final_res,
                  output overflowed, input ready);
  modport sink   (input valid, input sorted_value, input is_final_res,
                  input overflowed, output ready);
endinterface

// File: rtl/qs_ctrl.sv
// qs_ctrl: sequencer for load, partition, range stack and output phases
// depends on qs_pkg for the command and status structs
`timescale 1ns / 1ps

module qs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_is_final,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  qs_pkg::qs_sts_t sts,
  output qs_pkg::qs_cmd_t cmd
);
  import qs_pkg::*;

  typedef enum logic [17:0] {
    S_LOAD   = 18'h00001,
    S_START  = 18'h00002,
    S_POP    = 18'h00004,
    S_POPW   = 18'h00008,
    S_PIV_RD = 18'h00010,
    S_PIV_LD = 18'h00020,
    S_SL_RD  = 18'h00040,
    S_SL_CK  = 18'h00080,
    S_SR_RD  = 18'h00100,
    S_SR_CK  = 18'h00200,
    S_SW1    = 18'h00400,
    S_SW2    = 18'h00800,
    S_FIN1   = 18'h01000,
    S_FIN2   = 18'h02000,
    S_PUSH_R = 18'h04000,
    S_PUSH_L = 18'h08000,
    S_OUT_RD = 18'h10000,
    S_OUT_V  = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUT_V);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_sel = RD_L;
    cmd.wr_sel = WR_NONE;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.wr_sel = WR_IN;
          if (in_is_final) state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.push_init = 1'b1;
        cmd.k_clr     = 1'b1;
        state_nxt     = S_POP;
      end
      S_POP: begin
        if (sts.sp_zero) begin
          state_nxt = S_OUT_RD;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        cmd.load_range = 1'b1;
        state_nxt      = S_PIV_RD;
      end
      S_PIV_RD: begin
        cmd.rd_sel = RD_LO;
        state_nxt  = S_PIV_LD;
      end
      S_PIV_LD: begin
        cmd.pivot_ld = 1'b1;
        state_nxt    = S_SL_RD;
      end
      S_SL_RD: begin
        cmd.rd_sel = RD_L;
        state_nxt  = S_SL_CK;
      end
      S_SL_CK: begin
        if (sts.l_go) begin
          cmd.l_inc = 1'b1;
          state_nxt = S_SL_RD;
        end else begin
          cmd.a_ld  = 1'b1;
          state_nxt = S_SR_RD;
        end
      end
      S_SR_RD: begin
        cmd.rd_sel = RD_R;
        state_nxt  = S_SR_CK;
      end
      S_SR_CK: begin
        if (sts.r_go) begin
          cmd.r_dec = 1'b1;
          state_nxt = S_SR_RD;
        end else begin
          cmd.b_ld  = 1'b1;
          state_nxt = S_SW1;
        end
      end
      S_SW1: begin
        if (sts.l_lt_r) begin
          cmd.wr_sel = WR_L_B;
          state_nxt  = S_SW2;
        end else begin
          state_nxt = S_FIN1;
        end
      end
      S_SW2: begin
        cmd.wr_sel = WR_R_A;
        state_nxt  = S_SL_RD;
      end
      S_FIN1: begin
        cmd.wr_sel = WR_LO_B;
        state_nxt  = S_FIN2;
      end
      S_FIN2: begin
        cmd.wr_sel = WR_R_PIV;
        state_nxt  = S_PUSH_R;
      end
      S_PUSH_R: begin
        cmd.push_right = 1'b1;
        state_nxt      = S_PUSH_L;
      end
      S_PUSH_L: begin
        cmd.push_left = 1'b1;
        state_nxt     = S_POP;
      end
      S_OUT_RD: begin
        cmd.rd_sel = RD_K;
        state_nxt  = S_OUT_V;
      end
      S_OUT_V: begin
        cmd.rd_sel = RD_K;
        if (out_ready) begin
          if (sts.k_last) begin
            cmd.run_clr = 1'b1;
            state_nxt   = S_LOAD;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/qs_dp.sv
// qs_dp: element store, range stack, scan indices, pivot and run counters
// depends on qs_pkg for command/status structs and select codes
`timescale 1ns / 1ps

module qs_dp #(
  parameter int unsigned MAX_ITEMS   = qs_pkg::QS_MAX_ITEMS,
  parameter int unsigned VALUE_WIDTH = qs_pkg::QS_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qs_pkg::qs_cmd_t               cmd,
  output qs_pkg::qs_sts_t               sts,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic signed [VALUE_WIDTH-1:0] sorted_value,
  output logic                          is_final_res,
  output logic                          overflowed
);
  import qs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = 2 * IW;

  logic signed [VALUE_WIDTH-1:0] mem [MAX_ITEMS];
  logic [SW-1:0]                 stk [MAX_ITEMS];

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic          ovf_r, ovf_nxt;
  logic [IW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, l_r, l_nxt, r_r, r_nxt, k_r, k_nxt;
  logic signed [VALUE_WIDTH-1:0] piv_r, piv_nxt, a_r, a_nxt, b_r, b_nxt;
  logic signed [VALUE_WIDTH-1:0] rd_r;
  logic [SW-1:0] stk_rd_r;

  logic          count_full, ge2;
  logic [CW-1:0] count_m1, sp_m1;
  logic [IW:0]   r_p1, lo_p1, k_p1;
  logic [IW-1:0] r_m1;
  logic          push_r_ok, push_l_ok;
  logic          stk_we;
  logic [SW-1:0] stk_wdata;
  logic [IW-1:0] raddr, waddr;
  logic          we;
  logic signed [VALUE_WIDTH-1:0] wdata;

  assign count_full = (count_r == CW'(MAX_ITEMS));
  assign ge2        = (count_r >= CW'(2));
  assign count_m1   = count_r - 1'b1;
  assign sp_m1      = sp_r - 1'b1;
  assign r_p1       = {1'b0, r_r} + 1'b1;
  assign lo_p1      = {1'b0, lo_r} + 1'b1;
  assign k_p1       = {1'b0, k_r} + 1'b1;
  assign r_m1       = r_r - 1'b1;
  assign push_r_ok  = (r_p1 < {1'b0, hi_r});
  assign push_l_ok  = ({1'b0, r_r} > lo_p1);

  assign sts.sp_zero = (sp_r == '0);
  assign sts.l_go    = (rd_r <= piv_r) && (l_r < hi_r);
  assign sts.r_go    = (rd_r > piv_r) && (r_r > lo_r);
  assign sts.l_lt_r  = (l_r < r_r);
  assign sts.k_last  = (CW'(k_p1) == count_r);

  assign sorted_value = rd_r;
  assign is_final_res = sts.k_last;
  assign overflowed   = ovf_r;

  // range stack push, at most one per cycle
  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = '0;
    if (cmd.push_init && ge2) begin
      stk_we    = 1'b1;
      stk_wdata = {IW'(0), count_m1[IW-1:0]};
    end else if (cmd.push_right && push_r_ok) begin
      stk_we    = 1'b1;
      stk_wdata = {r_p1[IW-1:0], hi_r};
    end else if (cmd.push_left && push_l_ok) begin
      stk_we    = 1'b1;
      stk_wdata = {lo_r, r_m1};
    end
    if (sp_r >= CW'(MAX_ITEMS)) stk_we = 1'b0;
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_L:    raddr = l_r;
      RD_R:    raddr = r_r;
      RD_LO:   raddr = lo_r;
      RD_K:    raddr = k_r;
      default: raddr = l_r;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    waddr = l_r;
    wdata = b_r;
    case (cmd.wr_sel)
      WR_IN: begin
        we    = !count_full;
        waddr = count_r[IW-1:0];
        wdata = in_value;
      end
      WR_L_B: begin
        waddr = l_r;
        wdata = b_r;
      end
      WR_R_A: begin
        waddr = r_r;
        wdata = a_r;
      end
      WR_LO_B: begin
        waddr = lo_r;
        wdata = b_r;
      end
      WR_R_PIV: begin
        waddr = r_r;
        wdata = piv_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    sp_nxt    = sp_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    l_nxt     = l_r;
    r_nxt     = r_r;
    k_nxt     = k_r;
    piv_nxt   = piv_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    if (cmd.wr_sel == WR_IN) begin
      if (count_full) ovf_nxt = 1'b1;
      else            count_nxt = count_r + 1'b1;
    end
    if (stk_we)   sp_nxt = sp_r + 1'b1;
    if (cmd.pop)  sp_nxt = sp_m1;
    if (cmd.load_range) begin
      lo_nxt = stk_rd_r[SW-1:IW];
      hi_nxt = stk_rd_r[IW-1:0];
      l_nxt  = stk_rd_r[SW-1:IW];
      r_nxt  = stk_rd_r[IW-1:0];
    end
    if (cmd.pivot_ld) piv_nxt = rd_r;
    if (cmd.l_inc)    l_nxt   = l_r + 1'b1;
    if (cmd.r_dec)    r_nxt   = r_m1;
    if (cmd.a_ld)     a_nxt   = rd_r;
    if (cmd.b_ld)     b_nxt   = rd_r;
    if (cmd.k_clr)    k_nxt   = '0;
    if (cmd.k_inc)    k_nxt   = k_p1[IW-1:0];
    if (cmd.run_clr) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      sp_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      sp_r    <= '0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      sp_r    <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    l_r   <= l_nxt;
    r_r   <= r_nxt;
    k_r   <= k_nxt;
    piv_r <= piv_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  // element store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  // range stack: push at sp, pop reads sp - 1
  always_ff @(posedge clk) begin
    if (stk_we)  stk[sp_r[IW-1:0]] <= stk_wdata;
    if (cmd.pop) stk_rd_r <= stk[sp_m1[IW-1:0]];
  end

endmodule

// File: rtl/quicksort_engine.sv
// quicksort_engine: top level, joins the qs_ctrl sequencer and the qs_dp datapath
// depends on qs_pkg, qs_in_if / qs_out_if, qs_ctrl and qs_dp
`timescale 1ns / 1ps

// The engine collects signed values one item per cycle into an internal
// element store until an item with is_final set arrives, then sorts the held
// values ascending by quicksort (first element of each range as pivot, Hoare
// style scans, explicit range stack) and streams them out on the result
// channel, is_final_res marking the last one. At most MAX_ITEMS values are
// held; further values of the same set, a final one included, are dropped and
// every result of that run carries overflowed = 1. While sorting or emitting
// the engine takes no input. Sorting time grows with the elements compared
// in the left and right scans and with the number of partitioned ranges, and
// is worst on already sorted input. The single read port and single write
// port of the element store set the pace: each scan step is one registered
// read and each swap two writes.
module quicksort_engine #(
  parameter int unsigned MAX_ITEMS   = qs_pkg::QS_MAX_ITEMS,
  parameter int unsigned VALUE_WIDTH = qs_pkg::QS_VALUE_WIDTH
) (
  input logic      clk,
  input logic      rst_n,
  qs_in_if.sink    in_ch,
  qs_out_if.source out_ch
);
  import qs_pkg::*;

  // command and status between sequencer and datapath
  qs_cmd_t cmd;
  qs_sts_t sts;

  qs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_is_final (in_ch.is_final),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // store, stack, indices and pivot; result payload comes straight from
  // the registered read data of the store
  qs_dp #(
    .MAX_ITEMS   (MAX_ITEMS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_value     (in_ch.value),
    .sorted_value (out_ch.sorted_value),
    .is_final_res (out_ch.is_final_res),
    .overflowed   (out_ch.overflowed)
  );

endmodule
